// ===== rtl/wtsp_pkg.sv =====
`default_nettype none
package wtsp_pkg;

   localparam int WTSP_FRAC_BITS = 16;

   localparam int POS_W   = 32;
   localparam int MAT_W   = 64;
   localparam int COEF_W  = 32;
   localparam int PROD_W  = 64;
   localparam int SUM_W   = PROD_W + 2;
   localparam int DOT_W   = SUM_W + 1;
   localparam int CLIP_W  = 48;
   localparam int SCR_W   = 32;
   localparam int DISP_W  = 16;
   localparam int HALF_W  = DISP_W + 7;
   localparam int MAG_W   = CLIP_W;
   localparam int SPLIT_W = MAG_W / 2;
   localparam int PART_W  = SPLIT_W + HALF_W;
   localparam int NUM_W   = 72;
   localparam int DEN_W   = CLIP_W - 1;
   localparam int QBITS   = 34;
   localparam int DIV_LAT = QBITS + 1;
   localparam int FIFO_DEPTH = 4;
   localparam int CSR_IDX_W  = 3;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_BEHIND = 2'd1,
      ST_SMALL  = 2'd2,
      ST_SAT    = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROW0_A = 3'd0,
      CSR_ROW0_B = 3'd1,
      CSR_ROW1_A = 3'd2,
      CSR_ROW1_B = 3'd3,
      CSR_ROW3_A = 3'd4,
      CSR_ROW3_B = 3'd5,
      CSR_WIDTH  = 3'd6,
      CSR_HEIGHT = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [MAT_W-1:0] row0_a;
      logic [MAT_W-1:0] row0_b;
      logic [MAT_W-1:0] row1_a;
      logic [MAT_W-1:0] row1_b;
      logic [MAT_W-1:0] row3_a;
      logic [MAT_W-1:0] row3_b;
   } matrix_type;

   // what the front hands to the back for one item
   typedef struct packed {
      logic signed [CLIP_W-1:0] clip_x;
      logic signed [CLIP_W-1:0] clip_y;
      logic signed [CLIP_W-1:0] clip_w;
      logic                     clip_valid;
      status_type               status;
   } clip_item_type;

endpackage
`default_nettype wire

// ===== rtl/wtsp_front.sv =====
`default_nettype none
module wtsp_front import wtsp_pkg::*; #(
   parameter int FRAC_BITS = WTSP_FRAC_BITS
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   output logic                          in_ready,
   input  wire logic signed [POS_W-1:0]  pos_x,
   input  wire logic signed [POS_W-1:0]  pos_y,
   input  wire logic signed [POS_W-1:0]  pos_z,
   input  wire matrix_type               matrix,
   input  wire logic [DISP_W-1:0]        disp_width,
   input  wire logic [DISP_W-1:0]        disp_height,
   output logic                          out_valid,
   input  wire logic                     out_full,
   output clip_item_type                 out_item
);

   localparam logic signed [DOT_W-1:0] THRESH  = DOT_W'((64'd1 << FRAC_BITS) / 1000);
   localparam logic signed [DOT_W-1:0] DOT_MAX = DOT_W'(64'sh7FFF_FFFF_FFFF);
   localparam logic signed [DOT_W-1:0] DOT_MIN = -DOT_MAX - DOT_W'(1);

   logic en;
   logic v1_ff, v2_ff, v3_ff;

   logic signed [COEF_W-1:0] coef [9];
   logic signed [COEF_W-1:0] ofs_in [3];
   logic signed [PROD_W-1:0] prod_in [9];
   logic signed [PROD_W-1:0] prod_ff [9];
   logic signed [COEF_W-1:0] ofs1_ff [3];
   logic signed [SUM_W-1:0]  sum_in [3];
   logic signed [SUM_W-1:0]  sum_ff [3];
   logic signed [COEF_W-1:0] ofs2_ff [3];
   logic signed [DOT_W-1:0]  dot [3];
   logic signed [CLIP_W-1:0] clip [3];
   logic [2:0]               sat;
   clip_item_type            item_in;
   clip_item_type            item_ff;

   assign en       = !(v3_ff && out_full);
   assign in_ready = en;
   assign out_valid = v3_ff;
   assign out_item  = item_ff;

   always_comb begin
      coef[0] = matrix.row0_a[31:0];
      coef[1] = matrix.row0_a[63:32];
      coef[2] = matrix.row0_b[31:0];
      coef[3] = matrix.row1_a[31:0];
      coef[4] = matrix.row1_a[63:32];
      coef[5] = matrix.row1_b[31:0];
      coef[6] = matrix.row3_a[31:0];
      coef[7] = matrix.row3_a[63:32];
      coef[8] = matrix.row3_b[31:0];
      ofs_in[0] = matrix.row0_b[63:32];
      ofs_in[1] = matrix.row1_b[63:32];
      ofs_in[2] = matrix.row3_b[63:32];
      for (int r = 0; r < 3; r++) begin
         prod_in[3*r]   = coef[3*r]   * pos_x;
         prod_in[3*r+1] = coef[3*r+1] * pos_y;
         prod_in[3*r+2] = coef[3*r+2] * pos_z;
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         sum_in[r] = SUM_W'(prod_ff[3*r]) + SUM_W'(prod_ff[3*r+1]) + SUM_W'(prod_ff[3*r+2]);
      end
   end

   // floor of the exact sum, then the translation column
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         dot[r] = DOT_W'(sum_ff[r] >>> FRAC_BITS) + DOT_W'(ofs2_ff[r]);
         if (dot[r] > DOT_MAX) begin
            clip[r] = CLIP_W'(DOT_MAX);
            sat[r]  = 1'b1;
         end else if (dot[r] < DOT_MIN) begin
            clip[r] = CLIP_W'(DOT_MIN);
            sat[r]  = 1'b1;
         end else begin
            clip[r] = CLIP_W'(dot[r]);
            sat[r]  = 1'b0;
         end
      end
      item_in.clip_x     = clip[0];
      item_in.clip_y     = clip[1];
      item_in.clip_w     = clip[2];
      item_in.clip_valid = ~|sat;
      if (dot[2] <= THRESH) begin
         item_in.status = ST_BEHIND;
      end else if (disp_width <= DISP_W'(1) || disp_height <= DISP_W'(1)) begin
         item_in.status = ST_SMALL;
      end else begin
         item_in.status = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         ofs1_ff <= ofs_in;
         sum_ff  <= sum_in;
         ofs2_ff <= ofs1_ff;
         item_ff <= item_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/wtsp_fifo.sv =====
`default_nettype none
module wtsp_fifo import wtsp_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire clip_item_type push_item,
   input  wire logic          pop,
   output logic               full,
   output logic               empty,
   output clip_item_type      head
);

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   clip_item_type    mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ff, rd_ff;
   logic [CNT_W-1:0] count_ff;

   assign full  = count_ff == CNT_W'(FIFO_DEPTH);
   assign empty = count_ff == '0;
   assign head  = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + PTR_W'(1);
         if (pop)  rd_ff <= rd_ff + PTR_W'(1);
         if (push && !pop)      count_ff <= count_ff + CNT_W'(1);
         else if (pop && !push) count_ff <= count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_item;
   end

   assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("push into a full queue");
   assert property (@(posedge clock) disable iff (reset) !(pop && empty))
      else $error("pop from an empty queue");
   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_W'(FIFO_DEPTH))
      else $error("queue count out of range");

endmodule
`default_nettype wire

// ===== rtl/wtsp_div.sv =====
`default_nettype none
module wtsp_div import wtsp_pkg::*; (
   input  wire logic              clock,
   input  wire logic              en,
   input  wire logic [NUM_W-1:0]  num,
   input  wire logic [DEN_W-1:0]  den,
   output logic [QBITS-1:0]       quot,
   output logic                   ovf
);

   // restoring division, one quotient bit per stage; quotients of
   // 2^QBITS or more only flag ovf
   logic [DEN_W-1:0] rem_ff [QBITS+1];
   logic [QBITS-1:0] low_ff [QBITS+1];
   logic [QBITS-1:0] q_ff   [QBITS+1];
   logic [DEN_W-1:0] den_ff [QBITS+1];
   logic             ovf_ff [QBITS+1];
   logic [NUM_W-QBITS-1:0] num_hi;

   assign num_hi = num[NUM_W-1:QBITS];

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= DEN_W'(num_hi);
         low_ff[0] <= num[QBITS-1:0];
         q_ff[0]   <= '0;
         den_ff[0] <= den;
         ovf_ff[0] <= DEN_W'(num_hi) >= den;
      end
   end

   for (genvar k = 1; k <= QBITS; k++) begin : g_stage
      logic [DEN_W:0] shifted;
      logic           take;
      assign shifted = {rem_ff[k-1], low_ff[k-1][QBITS-k]};
      assign take    = shifted >= {1'b0, den_ff[k-1]};
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= take ? DEN_W'(shifted - {1'b0, den_ff[k-1]}) : DEN_W'(shifted);
            low_ff[k] <= low_ff[k-1];
            q_ff[k]   <= {q_ff[k-1][QBITS-2:0], take};
            den_ff[k] <= den_ff[k-1];
            ovf_ff[k] <= ovf_ff[k-1];
         end
      end
   end

   assign quot = q_ff[QBITS];
   assign ovf  = ovf_ff[QBITS];

endmodule
`default_nettype wire

// ===== rtl/wtsp_back.sv =====
`default_nettype none
module wtsp_back import wtsp_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_empty,
   input  wire clip_item_type      in_item,
   output logic                    in_pop,
   input  wire logic [DISP_W-1:0]  disp_width,
   input  wire logic [DISP_W-1:0]  disp_height,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output status_type              out_status,
   output logic signed [SCR_W-1:0] out_screen_x,
   output logic signed [SCR_W-1:0] out_screen_y,
   output logic signed [CLIP_W-1:0] out_clip_x,
   output logic signed [CLIP_W-1:0] out_clip_y,
   output logic signed [CLIP_W-1:0] out_clip_w,
   output logic                    out_clip_valid
);

   localparam int ACC_W = QBITS + 3;
   localparam logic signed [ACC_W-1:0] SCR_MAX = ACC_W'(32'sh7FFF_FFFF);
   localparam logic signed [ACC_W-1:0] SCR_MIN = -SCR_MAX - ACC_W'(1);

   typedef struct packed {
      clip_item_type     item;
      logic              neg_x;
      logic              neg_y;
      logic [HALF_W-1:0] half_w;
      logic [HALF_W-1:0] half_h;
   } side_type;

   typedef struct packed {
      logic signed [SCR_W-1:0] val;
      logic                    sat;
   } coord_type;

   // half +/- quotient, saturated to 32 bits
   function automatic coord_type screen_coord(logic [HALF_W-1:0] half, logic sub,
                                              logic [QBITS-1:0] q, logic ovf);
      logic signed [ACC_W-1:0] acc;
      coord_type               res;
      acc = sub ? ACC_W'(half) - ACC_W'(q) : ACC_W'(half) + ACC_W'(q);
      if (ovf) begin
         res.val = sub ? SCR_W'(SCR_MIN) : SCR_W'(SCR_MAX);
         res.sat = 1'b1;
      end else if (acc > SCR_MAX) begin
         res.val = SCR_W'(SCR_MAX);
         res.sat = 1'b1;
      end else if (acc < SCR_MIN) begin
         res.val = SCR_W'(SCR_MIN);
         res.sat = 1'b1;
      end else begin
         res.val = SCR_W'(acc);
         res.sat = 1'b0;
      end
      return res;
   endfunction

   logic en;
   logic v1_ff, v2_ff, v3_ff;
   logic [DIV_LAT-1:0] dv_ff;

   side_type         side_in, side1_ff, side2_ff, side3_ff;
   side_type         sided_ff [DIV_LAT];
   logic [MAG_W-1:0] magx_in, magy_in, magx_ff, magy_ff;
   logic [DEN_W-1:0] den1_ff, den2_ff, den3_ff;
   logic [PART_W-1:0] pxl_ff, pxh_ff, pyl_ff, pyh_ff;
   logic [NUM_W-1:0] numx_ff, numy_ff;
   logic [QBITS-1:0] qx, qy;
   logic             ovfx, ovfy;

   side_type          last;
   coord_type         cx, cy;
   status_type        status_in;
   logic signed [SCR_W-1:0] sx_in, sy_in;

   logic                    valid_ff;
   status_type              status_ff;
   logic signed [SCR_W-1:0] sx_ff, sy_ff;
   clip_item_type           item_ff;

   assign en     = !valid_ff || out_ready;
   assign in_pop = en && !in_empty;

   always_comb begin
      side_in.item   = in_item;
      side_in.neg_x  = in_item.clip_x < 0;
      side_in.neg_y  = in_item.clip_y < 0;
      side_in.half_w = {disp_width, 7'b0};
      side_in.half_h = {disp_height, 7'b0};
      magx_in = side_in.neg_x ? MAG_W'(-in_item.clip_x) : MAG_W'(in_item.clip_x);
      magy_in = side_in.neg_y ? MAG_W'(-in_item.clip_y) : MAG_W'(in_item.clip_y);
   end

   wtsp_div u_div_x (
      .clock (clock),
      .en    (en),
      .num   (numx_ff),
      .den   (den3_ff),
      .quot  (qx),
      .ovf   (ovfx)
   );

   wtsp_div u_div_y (
      .clock (clock),
      .en    (en),
      .num   (numy_ff),
      .den   (den3_ff),
      .quot  (qy),
      .ovf   (ovfy)
   );

   always_comb begin
      last = sided_ff[DIV_LAT-1];
      cx = screen_coord(last.half_w, last.neg_x, qx, ovfx);
      cy = screen_coord(last.half_h, !last.neg_y, qy, ovfy);
      if (last.item.status != ST_OK) begin
         status_in = last.item.status;
         sx_in     = '0;
         sy_in     = '0;
      end else begin
         status_in = (cx.sat || cy.sat) ? ST_SAT : ST_OK;
         sx_in     = cx.val;
         sy_in     = cy.val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         dv_ff    <= '0;
         valid_ff <= 1'b0;
      end else if (en) begin
         v1_ff    <= !in_empty;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         dv_ff    <= {dv_ff[DIV_LAT-2:0], v3_ff};
         valid_ff <= dv_ff[DIV_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side1_ff <= side_in;
         magx_ff  <= magx_in;
         magy_ff  <= magy_in;
         den1_ff  <= in_item.clip_w[DEN_W-1:0];

         side2_ff <= side1_ff;
         den2_ff  <= den1_ff;
         pxl_ff   <= PART_W'(magx_ff[SPLIT_W-1:0]) * PART_W'(side1_ff.half_w);
         pxh_ff   <= PART_W'(magx_ff[MAG_W-1:SPLIT_W]) * PART_W'(side1_ff.half_w);
         pyl_ff   <= PART_W'(magy_ff[SPLIT_W-1:0]) * PART_W'(side1_ff.half_h);
         pyh_ff   <= PART_W'(magy_ff[MAG_W-1:SPLIT_W]) * PART_W'(side1_ff.half_h);

         side3_ff <= side2_ff;
         den3_ff  <= den2_ff;
         numx_ff  <= NUM_W'(pxl_ff) + (NUM_W'(pxh_ff) << SPLIT_W);
         numy_ff  <= NUM_W'(pyl_ff) + (NUM_W'(pyh_ff) << SPLIT_W);

         sided_ff[0] <= side3_ff;
         for (int k = 1; k < DIV_LAT; k++) sided_ff[k] <= sided_ff[k-1];

         status_ff <= status_in;
         sx_ff     <= sx_in;
         sy_ff     <= sy_in;
         item_ff   <= last.item;
      end
   end

   assign out_valid      = valid_ff;
   assign out_status     = status_ff;
   assign out_screen_x   = sx_ff;
   assign out_screen_y   = sy_ff;
   assign out_clip_x     = item_ff.clip_x;
   assign out_clip_y     = item_ff.clip_y;
   assign out_clip_w     = item_ff.clip_w;
   assign out_clip_valid = item_ff.clip_valid;

endmodule
`default_nettype wire

// ===== rtl/world_to_screen_projection_core.sv =====
// channel   | ports            | item
// ----------+------------------+---------------------------------------------
// point in  | req_t*           | pos_x, pos_y, pos_z
// result    | rsp_t*           | status, screen xy, clip x/y/w, clip_valid
// config    | csr_*            | matrix rows 0,1,3 and display size
//
// One item per cycle sustained while the result side accepts; an item passes
// the dot-product registers, the queue, then the screen mapping, where the
// 35-stage divider (a loading stage, then one quotient bit per stage) sets the depth.
// Synchronous active-high reset clears the pipelines and queue and loads the
// default display size and a zero matrix.
// A stalled result holds only the back pipeline; the front keeps taking
// items until its four-entry queue fills.
`default_nettype none
module world_to_screen_projection_core import wtsp_pkg::*; #(
   parameter int FRAC_BITS = WTSP_FRAC_BITS
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [95:0]          req_tdata,   // pos_x, pos_y, pos_z
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   // status, screen_x, screen_y, clip_x, clip_y, clip_w, clip_valid, pad
   output logic [215:0]              rsp_tdata,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [MAT_W-1:0]     csr_wdata
);

   matrix_type        matrix_ff;
   logic [DISP_W-1:0] width_ff, height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         matrix_ff <= '0;
         width_ff  <= DISP_W'(1920);
         height_ff <= DISP_W'(1080);
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_ROW0_A: matrix_ff.row0_a <= csr_wdata;
            CSR_ROW0_B: matrix_ff.row0_b <= csr_wdata;
            CSR_ROW1_A: matrix_ff.row1_a <= csr_wdata;
            CSR_ROW1_B: matrix_ff.row1_b <= csr_wdata;
            CSR_ROW3_A: matrix_ff.row3_a <= csr_wdata;
            CSR_ROW3_B: matrix_ff.row3_b <= csr_wdata;
            CSR_WIDTH:  width_ff  <= csr_wdata[DISP_W-1:0];
            CSR_HEIGHT: height_ff <= csr_wdata[DISP_W-1:0];
            default: ;
         endcase
      end
   end

   logic          front_valid, fifo_full, fifo_empty, fifo_pop;
   clip_item_type front_item, fifo_head;

   wtsp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .pos_x       (req_tdata[31:0]),
      .pos_y       (req_tdata[63:32]),
      .pos_z       (req_tdata[95:64]),
      .matrix      (matrix_ff),
      .disp_width  (width_ff),
      .disp_height (height_ff),
      .out_valid   (front_valid),
      .out_full    (fifo_full),
      .out_item    (front_item)
   );

   wtsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid && !fifo_full),
      .push_item (front_item),
      .pop       (fifo_pop),
      .full      (fifo_full),
      .empty     (fifo_empty),
      .head      (fifo_head)
   );

   status_type               status;
   logic signed [SCR_W-1:0]  screen_x, screen_y;
   logic signed [CLIP_W-1:0] clip_x, clip_y, clip_w;
   logic                     clip_valid;

   wtsp_back u_back (
      .clock          (clock),
      .reset          (reset),
      .in_empty       (fifo_empty),
      .in_item        (fifo_head),
      .in_pop         (fifo_pop),
      .disp_width     (width_ff),
      .disp_height    (height_ff),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_status     (status),
      .out_screen_x   (screen_x),
      .out_screen_y   (screen_y),
      .out_clip_x     (clip_x),
      .out_clip_y     (clip_y),
      .out_clip_w     (clip_w),
      .out_clip_valid (clip_valid)
   );

   assign rsp_tdata = {5'b0, clip_valid, clip_w, clip_y, clip_x, screen_y, screen_x, status};

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (status == ST_BEHIND || status == ST_SMALL)
         |-> screen_x == '0 && screen_y == '0)
      else $error("screen position not zero on a rejected point");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && status == ST_SAT
         |-> screen_x == 32'sh7FFF_FFFF || screen_x == 32'sh8000_0000
          || screen_y == 32'sh7FFF_FFFF || screen_y == 32'sh8000_0000)
      else $error("saturated status without a screen value at a rail");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !clip_valid
         |-> clip_x == 48'sh7FFF_FFFF_FFFF || clip_x == 48'sh8000_0000_0000
          || clip_y == 48'sh7FFF_FFFF_FFFF || clip_y == 48'sh8000_0000_0000
          || clip_w == 48'sh7FFF_FFFF_FFFF || clip_w == 48'sh8000_0000_0000)
      else $error("clip_valid low without a clip value at a rail");

endmodule
`default_nettype wire

// ===== test/projection_checker.sv =====
module projection_checker import wtsp_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   input  wire logic                 req_tready,
   input  wire logic [95:0]          req_tdata,
   input  wire logic                 rsp_tvalid,
   input  wire logic                 rsp_tready,
   input  wire logic [215:0]         rsp_tdata,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [MAT_W-1:0]     csr_wdata,
   output int                        errors,
   output int                        pending
);

   localparam int FB = WTSP_FRAC_BITS;
   localparam logic signed [67:0] CLIP_HI = (68'sd1 <<< 47) - 68'sd1;
   localparam logic signed [67:0] CLIP_LO = -(68'sd1 <<< 47);
   localparam logic signed [63:0] SCR_HI = 64'sd2147483647;
   localparam logic signed [63:0] SCR_LO = -64'sd2147483648;

   typedef struct {
      status_type        status;
      logic [31:0]       screen_x;
      logic [31:0]       screen_y;
      logic [47:0]       clip_x;
      logic [47:0]       clip_y;
      logic [47:0]       clip_w;
      logic              clip_valid;
   } projection_type;

   matrix_type       mat;
   logic [15:0]      disp_w, disp_h;
   projection_type   expected_q[$];

   assign pending = expected_q.size();

   // exact row dot product with (x, y, z, 1), floored to FB fraction bits
   function automatic logic signed [67:0] row_dot(logic [63:0] ra, logic [63:0] rb,
         logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] z);
      logic signed [67:0] acc;
      acc = $signed(ra[31:0]) * x + $signed(ra[63:32]) * y + $signed(rb[31:0]) * z;
      acc = (acc >>> FB) + $signed(rb[63:32]);
      return acc;
   endfunction

   function automatic logic signed [47:0] clamp_clip(logic signed [67:0] v, ref logic sat);
      if (v > CLIP_HI) begin
         sat = 1'b1;
         return CLIP_HI[47:0];
      end
      if (v < CLIP_LO) begin
         sat = 1'b1;
         return CLIP_LO[47:0];
      end
      return v[47:0];
   endfunction

   // trunc(|c| * half / w), capped at 2^40, sign of c applied
   function automatic logic signed [63:0] scaled_ratio(logic signed [47:0] c,
         logic [22:0] half, logic signed [47:0] w);
      logic signed [71:0] cs;
      logic [71:0] mag, num, den, q;
      cs = c;
      mag = (cs < 0) ? -cs : cs;
      num = mag * half;
      den = w;
      q = num / den;
      if (q > (72'd1 << 40)) q = 72'd1 << 40;
      return (c < 0) ? -$signed(q[63:0]) : $signed(q[63:0]);
   endfunction

   function automatic logic [31:0] clamp_screen(logic signed [63:0] v, ref logic sat);
      if (v > SCR_HI) begin
         sat = 1'b1;
         return SCR_HI[31:0];
      end
      if (v < SCR_LO) begin
         sat = 1'b1;
         return SCR_LO[31:0];
      end
      return v[31:0];
   endfunction

   function automatic projection_type project(logic [95:0] pt);
      projection_type r;
      logic signed [67:0] wraw;
      logic signed [47:0] cx, cy, cw;
      logic csat, ssat;
      logic [22:0] hw, hh;
      csat = 1'b0;
      ssat = 1'b0;
      wraw = row_dot(mat.row3_a, mat.row3_b, pt[31:0], pt[63:32], pt[95:64]);
      cx = clamp_clip(row_dot(mat.row0_a, mat.row0_b, pt[31:0], pt[63:32], pt[95:64]), csat);
      cy = clamp_clip(row_dot(mat.row1_a, mat.row1_b, pt[31:0], pt[63:32], pt[95:64]), csat);
      cw = clamp_clip(wraw, csat);
      r.screen_x = '0;
      r.screen_y = '0;
      if (wraw <= ((68'sd1 <<< FB) / 68'sd1000)) begin
         r.status = ST_BEHIND;
      end else if (disp_w <= 16'd1 || disp_h <= 16'd1) begin
         r.status = ST_SMALL;
      end else begin
         hw = {disp_w, 7'd0};
         hh = {disp_h, 7'd0};
         r.screen_x = clamp_screen($signed({41'd0, hw}) + scaled_ratio(cx, hw, cw), ssat);
         r.screen_y = clamp_screen($signed({41'd0, hh}) - scaled_ratio(cy, hh, cw), ssat);
         r.status = ssat ? ST_SAT : ST_OK;
      end
      r.clip_x = cx;
      r.clip_y = cy;
      r.clip_w = cw;
      r.clip_valid = !csat;
      return r;
   endfunction

   task automatic compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
         errors++;
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
      end
   endtask

   initial errors = 0;

   always @(posedge clock) begin
      projection_type e;
      if (reset) begin
         mat <= '0;
         disp_w <= 16'd1920;
         disp_h <= 16'd1080;
         expected_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_ROW0_A: mat.row0_a <= csr_wdata;
               CSR_ROW0_B: mat.row0_b <= csr_wdata;
               CSR_ROW1_A: mat.row1_a <= csr_wdata;
               CSR_ROW1_B: mat.row1_b <= csr_wdata;
               CSR_ROW3_A: mat.row3_a <= csr_wdata;
               CSR_ROW3_B: mat.row3_b <= csr_wdata;
               CSR_WIDTH:  disp_w <= csr_wdata[15:0];
               CSR_HEIGHT: disp_h <= csr_wdata[15:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) expected_q.push_back(project(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected item, got %h", $time, rsp_tdata);
            end else begin
               e = expected_q.pop_front();
               compare_field("status", e.status, rsp_tdata[1:0]);
               compare_field("screen_x", e.screen_x, rsp_tdata[33:2]);
               compare_field("screen_y", e.screen_y, rsp_tdata[65:34]);
               compare_field("clip_x", e.clip_x, rsp_tdata[113:66]);
               compare_field("clip_y", e.clip_y, rsp_tdata[161:114]);
               compare_field("clip_w", e.clip_w, rsp_tdata[209:162]);
               compare_field("clip_valid", e.clip_valid, rsp_tdata[210]);
            end
         end
      end
   end

endmodule

// ===== test/tb_top.sv =====
module tb_top;
   import wtsp_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam logic [31:0] ONE = 32'h0001_0000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [95:0]          req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [215:0]         rsp_tdata;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [MAT_W-1:0]     csr_wdata = '0;
   int                   errors, pending;
   int                   tx_idle = 29, rx_idle = 53;
   int                   rx_hold = 0;
   int                   cycles = 0;

   world_to_screen_projection_core uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   projection_checker chk (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .errors(errors), .pending(pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // receiver: random stalls, plus long hold-offs on request
   always @(negedge clock) begin
      if (rx_hold > 0) begin
         rx_hold--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle);
      end
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      while ($urandom_range(99) < tx_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {z, y, x};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (50) @(negedge clock);
   endtask

   // one write cycle, then the enable low again before the task returns
   task automatic write_reg(csr_index_type idx, logic [63:0] v);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic load_matrix(logic [63:0] r0a, logic [63:0] r0b, logic [63:0] r1a,
         logic [63:0] r1b, logic [63:0] r3a, logic [63:0] r3b);
      write_reg(CSR_ROW0_A, r0a);
      write_reg(CSR_ROW0_B, r0b);
      write_reg(CSR_ROW1_A, r1a);
      write_reg(CSR_ROW1_B, r1b);
      write_reg(CSR_ROW3_A, r3a);
      write_reg(CSR_ROW3_B, r3b);
   endtask

   // camera-like matrix: scale on x/y, w = z + offset
   task automatic load_camera();
      load_matrix({32'd0, 32'($urandom_range(1 << 17, 1))}, {$urandom, 32'd0},
                  {32'($urandom_range(1 << 17, 1)), 32'd0}, {$urandom, 32'd0},
                  {32'd0, 32'd0}, {32'($urandom_range(1 << 16)), ONE});
   endtask

   initial begin
      logic [31:0] zz;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // zero matrix after reset: every point is behind the camera
      send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
      send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      drain_results();

      // w = z exactly, threshold neighborhood and screen saturation
      load_matrix({32'd0, ONE}, 64'd0, {ONE, 32'd0}, 64'd0, 64'd0, {32'd0, ONE});
      send_point(32'h0, 32'h0, 32'd65);
      send_point(32'h0, 32'h0, 32'd66);
      send_point(32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000);
      send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'd66);
      send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'd66);
      send_point(32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF);
      send_point(32'h0, 32'h0, 32'h8000_0000);
      drain_results();
      write_reg(CSR_WIDTH, 64'd1);
      send_point(32'h0, 32'h0, 32'h0001_0000);
      send_point(32'h0, 32'h0, 32'd10);
      drain_results();
      write_reg(CSR_WIDTH, 64'd640);
      write_reg(CSR_HEIGHT, 64'd0);
      send_point(32'h0, 32'h0, 32'h0001_0000);
      drain_results();
      write_reg(CSR_WIDTH, 64'hFFFF);
      write_reg(CSR_HEIGHT, 64'hFFFF);
      send_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd100);
      drain_results();

      // clip saturation: extreme matrix entries times extreme points
      load_matrix({2{32'h8000_0000}}, {32'h7FFF_FFFF, 32'h8000_0000},
                  {2{32'h7FFF_FFFF}}, {32'h8000_0000, 32'h7FFF_FFFF},
                  {2{32'h8000_0000}}, {32'h7FFF_FFFF, 32'h8000_0000});
      send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      drain_results();

      for (int ph = 0; ph < 6; ph++) begin
         tx_idle = (ph < 2) ? 29 : (ph < 4) ? 53 : 0;
         rx_idle = (ph < 2) ? 53 : (ph < 4) ? 29 : 0;
         case (ph % 3)
            0: load_camera();
            1: load_matrix({$urandom, $urandom}, {$urandom, $urandom},
                           {$urandom, $urandom}, {$urandom, $urandom},
                           {$urandom, $urandom}, {$urandom, $urandom});
            default: begin
               load_camera();
               write_reg(CSR_ROW3_A, {$urandom >> 12, $urandom >> 12});
            end
         endcase
         write_reg(CSR_WIDTH, (ph == 4) ? 64'hFFFF : 64'($urandom_range(4000)));
         write_reg(CSR_HEIGHT, (ph == 5) ? 64'd2 : 64'($urandom_range(4000)));
         for (int i = 0; i < 250; i++) begin
            if (i == 100) rx_hold = 80;
            if ($urandom_range(9) < 7)
               zz = $urandom_range(32'h0100_0000);
            else
               zz = $urandom;
            if ($urandom_range(3) == 0)
               send_point($urandom, $urandom, $urandom);
            else
               send_point(32'($signed($urandom) >>> $urandom_range(31)),
                          32'($signed($urandom) >>> $urandom_range(31)), zz);
         end
         drain_results();
      end

      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
